/* sv/nnd_pkg.sv */
// ----------------------------------------------------------------------------
// nnd_pkg: shared constants for the nearest-neighbor downscaler
// Pixel width, fixed-point fraction width, register indexes and reset sizes.
// ----------------------------------------------------------------------------
package nnd_pkg;

  localparam int PIXEL_W   = 8;
  localparam int FRAC_BITS = 16;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_WIDTH  = 2'd0,
    REG_SRC_HEIGHT = 2'd1,
    REG_DST_WIDTH  = 2'd2,
    REG_DST_HEIGHT = 2'd3
  } cfg_reg_t;

  localparam int RST_SRC_WIDTH  = 240;
  localparam int RST_SRC_HEIGHT = 180;
  localparam int RST_DST_WIDTH  = 28;
  localparam int RST_DST_HEIGHT = 28;

endpackage

/* sv/nearest_neighbor_downscale.sv */
// ----------------------------------------------------------------------------
// nearest_neighbor_downscale: streaming nearest-neighbor image downscaler
// Forwards the source pixels that map onto a smaller destination grid.
// ----------------------------------------------------------------------------
//  channel | signals                                  | transfer when
//  --------+------------------------------------------+------------------------
//  input   | in_valid, in_stall, pixel_in             | in_valid & !in_stall
//  output  | out_valid, out_stall, pixel_out,         | out_valid & !out_stall
//          | frame_last                               |
//  config  | cfg_we, cfg_index, cfg_data              | cfg_we
//
// One pixel per clock while in_stall is low; the pick decision is made at the
// input transfer and the result is registered in the output register, or in
// the skid entry while the output is held. After reset and each register
// write, two restoring dividers form the DIM_BITS.16 steps, one quotient bit per
// cycle, holding in_stall high. A two-entry output (register plus skid) keeps
// input flowing while a result waits; else in_stall rises only for a full skid.
module nearest_neighbor_downscale
  import nnd_pkg::*;
#(
  parameter int DIM_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_BITS-1:0]  cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [PIXEL_W-1:0]   pixel_in,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [PIXEL_W-1:0]   pixel_out,
  output logic                 frame_last
);

  localparam int ACC_W = DIM_BITS + FRAC_BITS;
  localparam int CNT_W = $clog2(ACC_W + 1);
  localparam logic [DIM_BITS-1:0] ONE = DIM_BITS'(1);

  logic [DIM_BITS-1:0] src_width, src_height, dst_width, dst_height;
  logic [DIM_BITS-1:0] eff_sw, eff_sh, eff_dw, eff_dh, dw_raw, dh_raw;

  logic [DIM_BITS-1:0] source_column, source_row, dest_column, dest_row;
  logic [ACC_W-1:0]    column_accumulator, row_accumulator;
  logic [ACC_W-1:0]    column_step, row_step;

  // divider state
  logic                div_load;
  logic [CNT_W-1:0]    div_cnt;
  logic [ACC_W-1:0]    cquot, rquot, cquot_next, rquot_next;
  logic [DIM_BITS-1:0] crem, rrem, crem_next, rrem_next;
  logic [DIM_BITS:0]   ctrial, rtrial;
  logic                cge, rge;
  logic                busy;

  // output register and skid entry
  logic               skid_valid;
  logic [PIXEL_W-1:0] skid_pixel;
  logic               skid_last;

  logic in_xfer, out_xfer;
  logic row_hit, col_hit, hit_last, col_wrap, row_wrap;

  // effective sizes: zero acts as one, destination clamped to source
  always_comb begin
    eff_sw = (src_width  == '0) ? ONE : src_width;
    eff_sh = (src_height == '0) ? ONE : src_height;
    dw_raw = (dst_width  == '0) ? ONE : dst_width;
    dh_raw = (dst_height == '0) ? ONE : dst_height;
    eff_dw = (dw_raw > eff_sw) ? eff_sw : dw_raw;
    eff_dh = (dh_raw > eff_sh) ? eff_sh : dh_raw;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= DIM_BITS'(RST_SRC_WIDTH);
      src_height <= DIM_BITS'(RST_SRC_HEIGHT);
      dst_width  <= DIM_BITS'(RST_DST_WIDTH);
      dst_height <= DIM_BITS'(RST_DST_HEIGHT);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_SRC_WIDTH:  src_width  <= cfg_data;
        REG_SRC_HEIGHT: src_height <= cfg_data;
        REG_DST_WIDTH:  dst_width  <= cfg_data;
        REG_DST_HEIGHT: dst_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // restoring division step: shift one numerator bit into the remainder
  always_comb begin
    ctrial     = {crem, cquot[ACC_W-1]};
    cge        = ctrial >= {1'b0, eff_dw};
    crem_next  = cge ? DIM_BITS'(ctrial - {1'b0, eff_dw}) : ctrial[DIM_BITS-1:0];
    cquot_next = {cquot[ACC_W-2:0], cge};
    rtrial     = {rrem, rquot[ACC_W-1]};
    rge        = rtrial >= {1'b0, eff_dh};
    rrem_next  = rge ? DIM_BITS'(rtrial - {1'b0, eff_dh}) : rtrial[DIM_BITS-1:0];
    rquot_next = {rquot[ACC_W-2:0], rge};
  end

  assign busy = div_load || (div_cnt != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      div_load <= 1'b1;
      div_cnt  <= '0;
    end else if (cfg_we) begin
      div_load <= 1'b1;
      div_cnt  <= '0;
    end else if (div_load) begin
      div_load <= 1'b0;
      div_cnt  <= CNT_W'(ACC_W);
    end else if (div_cnt != '0) begin
      div_cnt <= div_cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (div_load) begin
      cquot <= {eff_sw, FRAC_BITS'(0)};
      rquot <= {eff_sh, FRAC_BITS'(0)};
      crem  <= '0;
      rrem  <= '0;
    end else if (div_cnt != '0) begin
      cquot <= cquot_next;
      rquot <= rquot_next;
      crem  <= crem_next;
      rrem  <= rrem_next;
      if (div_cnt == CNT_W'(1)) begin
        column_step <= cquot_next + ACC_W'(1);
        row_step    <= rquot_next + ACC_W'(1);
      end
    end
  end

  // pick decision for the pixel at the input
  assign in_stall = busy || skid_valid;
  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;

  always_comb begin
    row_hit  = (dest_row < eff_dh) &&
               (source_row == row_accumulator[ACC_W-1:FRAC_BITS]);
    col_hit  = row_hit && (dest_column < eff_dw) &&
               (source_column == column_accumulator[ACC_W-1:FRAC_BITS]);
    hit_last = (dest_row == eff_dh - ONE) && (dest_column == eff_dw - ONE);
    col_wrap = ({1'b0, source_column} + {1'b0, ONE}) >= {1'b0, eff_sw};
    row_wrap = ({1'b0, source_row} + {1'b0, ONE}) >= {1'b0, eff_sh};
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      source_column      <= '0;
      source_row         <= '0;
      dest_column        <= '0;
      dest_row           <= '0;
      column_accumulator <= '0;
      row_accumulator    <= '0;
    end else if (in_xfer) begin
      if (col_wrap) begin
        source_column      <= '0;
        dest_column        <= '0;
        column_accumulator <= '0;
        if (row_wrap) begin
          source_row      <= '0;
          dest_row        <= '0;
          row_accumulator <= '0;
        end else begin
          source_row <= source_row + ONE;
          if (row_hit) begin
            dest_row        <= dest_row + ONE;
            row_accumulator <= row_accumulator + row_step;
          end
        end
      end else begin
        source_column <= source_column + ONE;
        if (col_hit) begin
          dest_column        <= dest_column + ONE;
          column_accumulator <= column_accumulator + column_step;
        end
      end
    end
  end

  // output register with one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_xfer) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (!out_valid || out_xfer) begin
      out_valid <= in_xfer && col_hit;
    end else if (in_xfer && col_hit) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_xfer) begin
        pixel_out  <= skid_pixel;
        frame_last <= skid_last;
      end
    end else if (!out_valid || out_xfer) begin
      pixel_out  <= pixel_in;
      frame_last <= hit_last;
    end else begin
      skid_pixel <= pixel_in;
      skid_last  <= hit_last;
    end
  end

endmodule

/* sv/nnd_checker.sv */
// ----------------------------------------------------------------------------
// nnd_checker: port-level checks for the nearest-neighbor downscaler
// Watches reset, configuration and output behavior on the top-level ports.
// ----------------------------------------------------------------------------
module nnd_checker
  import nnd_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               cfg_we,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [PIXEL_W-1:0] pixel_out,
  input logic               frame_last
);

  // no result survives reset
  a_rst_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // steps are recomputed after reset before any pixel is taken
  a_rst_busy: assert property (@(posedge clk) rst |=> in_stall ##1 in_stall)
    else $error("input taken while steps recompute after reset");

  // a register write restarts the frame and holds off input
  a_cfg_busy: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> in_stall ##1 in_stall)
    else $error("input taken while steps recompute after write");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pixel_out) && $stable(frame_last))
    else $error("stalled result changed");

endmodule

bind nearest_neighbor_downscale nnd_checker u_nnd_checker (
  .clk        (clk),
  .rst        (rst),
  .cfg_we     (cfg_we),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .pixel_out  (pixel_out),
  .frame_last (frame_last)
);
